FILE: hw/rtl/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg: shared definitions for the button debounce event queue
// Sizes, command codes, register indexes and the structs passed between units.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int BUTTONS    = 7;
  localparam int FIFO_DEPTH = 16;

  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int ENTRY_W = BUTTONS + 1;

  localparam int CMD_W    = 2;
  localparam int DEB_W    = 8;
  localparam int AGE_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Stream word widths, rounded up to whole bytes.
  localparam int IN_RAW_W  = CMD_W + BUTTONS;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 2 * BUTTONS + 2 + CNT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_FEATURES = 2'd3
  } reg_idx_t;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd4;
  localparam logic [AGE_W-1:0] HOLD_RST     = 16'd100;
  localparam logic [AGE_W-1:0] REPEAT_RST   = 16'd25;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_cycles;
    logic [AGE_W-1:0] hold_cycles;
    logic [AGE_W-1:0] repeat_cycles;
    logic             hold_features_on;
  } cfg_t;

  // Request from the debounce unit and the command decoder to the queue.
  typedef struct packed {
    logic               push;
    logic [ENTRY_W-1:0] entry;
    logic               pop;
    logic               clear;
  } queue_req_t;

endpackage

FILE: hw/rtl/bde_debounce.sv
// ----------------------------------------------------------------------------
// bde_debounce: debounce filter, press accumulation and hold timer
// Updates the scalar button state on each accepted tick and raises at most
// one event per tick for the queue.
// ----------------------------------------------------------------------------
module bde_debounce (
  input  logic                        clk,
  input  logic                        rst,
  input  bde_pkg::cfg_t               cfg,
  input  logic                        tick,
  input  logic [bde_pkg::BUTTONS-1:0] raw_buttons,
  output logic [bde_pkg::BUTTONS-1:0] debounced_next,
  output logic                        push,
  output logic [bde_pkg::ENTRY_W-1:0] push_entry
);
  import bde_pkg::*;

  logic [BUTTONS-1:0] last_raw, last_raw_next;
  logic [DEB_W-1:0]   stable_count, stable_count_next;
  logic [BUTTONS-1:0] debounced;
  logic [BUTTONS-1:0] pressed_set, pressed_set_next;
  logic               skip_release, skip_release_next;
  logic [AGE_W-1:0]   hold_age, hold_age_next;
  logic               hf;
  logic               change;
  logic               hold_due;

  always_comb begin
    hf                = cfg.hold_features_on;
    last_raw_next     = raw_buttons;
    if (raw_buttons == last_raw) begin
      stable_count_next = (stable_count == '1) ? stable_count : stable_count + 1'b1;
    end else begin
      stable_count_next = DEB_W'(1);
    end
    // Only a tick may move the debounced state; other words report it as is.
    change            = tick && (debounced != last_raw_next) &&
                        (stable_count_next >= cfg.debounce_cycles);
    debounced_next    = change ? last_raw_next : debounced;
    pressed_set_next  = pressed_set;
    skip_release_next = skip_release;
    hold_age_next     = hold_age;
    push              = 1'b0;
    push_entry        = {1'b0, pressed_set};

    if (change) begin
      if (last_raw_next != '0) begin
        if (!hf || pressed_set == '0 || !skip_release) begin
          pressed_set_next = pressed_set | last_raw_next;
          if (hf) begin
            hold_age_next = '0;
          end
        end
      end else if (pressed_set != '0) begin
        push              = !hf || !skip_release;
        push_entry        = {1'b0, pressed_set};
        skip_release_next = 1'b0;
        pressed_set_next  = '0;
      end
    end

    // Hold and repeat timer, run only with hold features on: the first event
    // after hold_cycles, then one every repeat_cycles while the set stays down.
    hold_due = (pressed_set_next != '0) &&
               ((!skip_release_next && cfg.hold_cycles != '0 &&
                 hold_age_next >= cfg.hold_cycles) ||
                (skip_release_next && cfg.repeat_cycles != '0 &&
                 hold_age_next >= cfg.repeat_cycles));
    if (hf) begin
      if (hold_due) begin
        skip_release_next = 1'b1;
        hold_age_next     = '0;
        push              = 1'b1;
        push_entry        = {1'b1, pressed_set_next};
      end
      if (hold_age_next != '1) begin
        hold_age_next = hold_age_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= '0;
      stable_count <= '0;
      debounced    <= '0;
      pressed_set  <= '0;
      skip_release <= 1'b0;
      hold_age     <= '0;
    end else if (tick) begin
      last_raw     <= last_raw_next;
      stable_count <= stable_count_next;
      debounced    <= debounced_next;
      pressed_set  <= pressed_set_next;
      skip_release <= skip_release_next;
      hold_age     <= hold_age_next;
    end
  end

  // A suppressed release only exists inside a press episode.
  a_skip_in_episode: assert property (@(posedge clk) disable iff (rst)
    skip_release |-> (pressed_set != '0))
    else $error("skip_release set with no collected buttons");

  // Whenever any button is debounced down, the collected set is not empty.
  a_pressed_covers: assert property (@(posedge clk) disable iff (rst)
    (debounced != '0) |-> (pressed_set != '0))
    else $error("buttons down but press set empty");

endmodule

FILE: hw/rtl/bde_event_queue.sv
// ----------------------------------------------------------------------------
// bde_event_queue: event FIFO on a single synchronous memory
// Push drops when full, pop on empty reports a miss, clear empties the queue.
// Read data is registered and holds until the next pop that hits.
// ----------------------------------------------------------------------------
module bde_event_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  bde_pkg::queue_req_t         req,
  output logic [bde_pkg::CNT_W-1:0]   count_next,
  output logic                        pop_hit,
  output logic [bde_pkg::ENTRY_W-1:0] rd_data
);
  import bde_pkg::*;

  logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   count;
  logic               push_ok;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    push_ok     = req.push && (count != CNT_W'(FIFO_DEPTH));
    pop_hit     = req.pop && (count != '0);
    wr_ptr_next = push_ok ? ptr_inc(wr_ptr) : wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (req.clear) begin
      rd_ptr_next = wr_ptr;
      count_next  = '0;
    end else if (pop_hit) begin
      rd_ptr_next = ptr_inc(rd_ptr);
      count_next  = count - 1'b1;
    end else if (push_ok) begin
      count_next  = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // A tick writes and a pop reads, never both in the same word, so the read
  // never races a write to the same entry.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= req.entry;
    end
    if (pop_hit) begin
      rd_data <= mem[rd_ptr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("event count above queue depth");

  a_ptr_span: assert property (@(posedge clk) disable iff (rst)
    ((int'(rd_ptr) + int'(count)) == int'(wr_ptr)) ||
    ((int'(rd_ptr) + int'(count)) == int'(wr_ptr) + FIFO_DEPTH))
    else $error("queue pointers disagree with count");

endmodule

FILE: hw/rtl/button_debounce_event_queue.sv
// ----------------------------------------------------------------------------
// button_debounce_event_queue: debounced buttons with press, hold and repeat
// events kept in a FIFO that is popped through the same input stream.
// ----------------------------------------------------------------------------
// Every input word carries a command: a sample tick with the raw button
// vector, a pop of one queued event, or a clear of the queue. Each word gives
// exactly one output word with the debounced state, the popped event (or a
// miss, with event_valid low) and the number of events left. The block takes
// one word per clock: the debounce and hold state sits in registers updated in
// the accept cycle, and the events live in a 16-entry synchronous memory whose
// registered read fills a middle stage. Results pass the middle stage and the
// output register; the rate stays at one word per clock as long as the output
// side takes words; s_tready follows m_tready through the two stages.
// Configuration writes on the cfg port are meant for idle periods only.
// ----------------------------------------------------------------------------
module button_debounce_event_queue (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: command [1:0], raw_buttons [8:2], zero fill above
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bde_pkg::IN_W-1:0]      s_tdata,
  // m_tdata: debounced_buttons [6:0], event_valid [7], event_buttons [14:8],
  // event_hold [15], events_waiting [20:16], zero fill above
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bde_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_wr_en,
  input  logic [bde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bde_pkg::CFG_W-1:0]     cfg_data
);
  import bde_pkg::*;

  cfg_t               cfg;
  cmd_t               cmd;
  logic [BUTTONS-1:0] raw;
  logic               accept;
  logic               tick;
  logic [BUTTONS-1:0] debounced_next;
  logic               push;
  logic [ENTRY_W-1:0] push_entry;
  queue_req_t         qreq;
  logic [CNT_W-1:0]   count_next;
  logic               pop_hit;
  logic [ENTRY_W-1:0] rd_data;

  // Middle stage: waits for the memory read data.
  logic               s1_valid;
  logic [BUTTONS-1:0] s1_debounced;
  logic               s1_hit;
  logic [CNT_W-1:0]   s1_count;
  logic               s1_advance;

  // Output register.
  logic               out_valid;
  logic [BUTTONS-1:0] out_debounced;
  logic               out_event_valid;
  logic [BUTTONS-1:0] out_event_buttons;
  logic               out_event_hold;
  logic [CNT_W-1:0]   out_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_cycles  <= DEBOUNCE_RST;
      cfg.hold_cycles      <= HOLD_RST;
      cfg.repeat_cycles    <= REPEAT_RST;
      cfg.hold_features_on <= 1'b1;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg.debounce_cycles  <= cfg_data[DEB_W-1:0];
        REG_HOLD:     cfg.hold_cycles      <= cfg_data[AGE_W-1:0];
        REG_REPEAT:   cfg.repeat_cycles    <= cfg_data[AGE_W-1:0];
        REG_FEATURES: cfg.hold_features_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The output register frees when it is empty or being taken, and the
  // middle stage moves whenever the output register frees.
  assign s1_advance = !out_valid || m_tready;
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;

  assign cmd  = cmd_t'(s_tdata[CMD_W-1:0]);
  assign raw  = s_tdata[CMD_W +: BUTTONS];
  assign tick = accept && (cmd == CMD_TICK);

  bde_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .tick           (tick),
    .raw_buttons    (raw),
    .debounced_next (debounced_next),
    .push           (push),
    .push_entry     (push_entry)
  );

  always_comb begin
    qreq.push  = tick && push;
    qreq.entry = push_entry;
    qreq.pop   = accept && (cmd == CMD_POP);
    qreq.clear = accept && (cmd == CMD_CLEAR);
  end

  bde_event_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .req        (qreq),
    .count_next (count_next),
    .pop_hit    (pop_hit),
    .rd_data    (rd_data)
  );

  // Middle stage. The debounced state is only updated on a tick, so the
  // value after a non-tick word is simply the current one.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (accept) begin
      s1_debounced <= debounced_next;
      s1_hit       <= pop_hit;
      s1_count     <= count_next;
    end
  end

  // Output register; a miss reports zeros in the event fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
    if (s1_advance && s1_valid) begin
      out_debounced     <= s1_debounced;
      out_event_valid   <= s1_hit;
      out_event_buttons <= s1_hit ? rd_data[BUTTONS-1:0] : '0;
      out_event_hold    <= s1_hit && rd_data[BUTTONS];
      out_count         <= s1_count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_count, out_event_hold, out_event_buttons,
                            out_event_valid, out_debounced});

  // A miss never carries event bits.
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_event_valid) |-> (out_event_buttons == '0 && !out_event_hold))
    else $error("event bits on a pop miss");

  // A pop that hits leaves the queue below full.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_hit) |-> (s1_count < CNT_W'(FIFO_DEPTH)))
    else $error("pop hit left a full queue");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the button debounce event queue
// Streams tick, pop, clear and unused command words into the block, predicts
// every output word with a cycle-free model of the debounce, hold and repeat
// logic and of the event FIFO, and checks each output word in order.
// ----------------------------------------------------------------------------
module tb;
  import bde_pkg::*;

  // One pending input word: the command and the raw button vector.
  typedef struct packed {
    cmd_t               cmd;
    logic [BUTTONS-1:0] keys;
  } key_word_t;

  // One output word, declared so that the last field lands in the low bits,
  // exactly as on m_tdata.
  typedef struct packed {
    logic [CNT_W-1:0]   waiting;
    logic               hold;
    logic [BUTTONS-1:0] ev_btns;
    logic               ev_valid;
    logic [BUTTONS-1:0] btns;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  button_debounce_event_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Words waiting to be driven, and the output words predicted for the words
  // the block has already taken, oldest first.
  key_word_t key_words_pending[$];
  result_t   expected_reports[$];

  int unsigned queued_words = 0;
  int unsigned fail_count   = 0;
  int unsigned rx_hold_off  = 0;
  bit          calm         = 1'b0;
  bit          in_taken     = 1'b0;

  // Model copy of the configuration, starting at the reset values.
  logic [DEB_W-1:0] cfg_debounce = DEBOUNCE_RST;
  logic [AGE_W-1:0] cfg_hold     = HOLD_RST;
  logic [AGE_W-1:0] cfg_repeat   = REPEAT_RST;
  logic             cfg_features = 1'b1;

  // Model copy of the block state.
  logic [BUTTONS-1:0] raw_prev      = '0;
  logic [DEB_W-1:0]   same_count    = '0;
  logic [BUTTONS-1:0] stable_keys   = '0;
  logic [BUTTONS-1:0] episode_keys  = '0;
  logic               hold_reported = 1'b0;
  logic [AGE_W-1:0]   held_ticks    = '0;
  logic [ENTRY_W-1:0] event_fifo[$];

  // A full queue silently drops the new event.
  function automatic void store_event(logic [ENTRY_W-1:0] entry);
    if (event_fifo.size() < FIFO_DEPTH) event_fifo.push_back(entry);
  endfunction

  // One sample tick: debounce, collect the pressed set, emit release and
  // hold or repeat events.
  function automatic void sample_keys(logic [BUTTONS-1:0] keys);
    if (keys == raw_prev) begin
      if (same_count != '1) same_count = same_count + 1'b1;
    end else begin
      raw_prev   = keys;
      same_count = DEB_W'(1);
    end

    // A debounce setting of zero behaves like one, since the count is at
    // least one after any tick.
    if (stable_keys != raw_prev && same_count >= cfg_debounce) begin
      stable_keys = raw_prev;
      if (stable_keys != '0) begin
        // Once a hold event went out, further presses in the same episode
        // neither grow the set nor restart the hold timer.
        if (!cfg_features || episode_keys == '0 || !hold_reported) begin
          episode_keys = episode_keys | stable_keys;
          if (cfg_features) held_ticks = '0;
        end
      end else if (episode_keys != '0) begin
        if (!cfg_features || !hold_reported) store_event({1'b0, episode_keys});
        hold_reported = 1'b0;
        episode_keys  = '0;
      end
    end

    if (cfg_features) begin
      if (episode_keys != '0 &&
          ((!hold_reported && cfg_hold != '0 && held_ticks >= cfg_hold) ||
           (hold_reported && cfg_repeat != '0 && held_ticks >= cfg_repeat))) begin
        hold_reported = 1'b1;
        held_ticks    = '0;
        store_event({1'b1, episode_keys});
      end
      if (held_ticks != '1) held_ticks = held_ticks + 1'b1;
    end
  endfunction

  // Applies one accepted word to the model and returns the output word it
  // must produce.
  function automatic result_t apply_word(cmd_t cmd, logic [BUTTONS-1:0] keys);
    result_t            r;
    logic [ENTRY_W-1:0] entry;
    r = '0;
    case (cmd)
      CMD_TICK: sample_keys(keys);
      CMD_POP: begin
        if (event_fifo.size() != 0) begin
          entry      = event_fifo.pop_front();
          r.ev_valid = 1'b1;
          r.ev_btns  = entry[BUTTONS-1:0];
          r.hold     = entry[BUTTONS];
        end
      end
      CMD_CLEAR: event_fifo.delete();
      default: ;
    endcase
    r.btns    = stable_keys;
    r.waiting = CNT_W'(event_fifo.size());
    return r;
  endfunction

  // Sender: a new word goes out once the previous one was taken at the last
  // rising edge. A free slot is left empty about one time in seven unless calm is set.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (key_words_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
        key_word_t w;
        logic [IN_W-1:0] bits;
        w = key_words_pending.pop_front();
        bits = '0;
        bits[CMD_W-1:0] = w.cmd;
        bits[CMD_W +: BUTTONS] = w.keys;
        s_tdata  <= bits;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted down here when the
  // stimulus asks for one, so that both stages fill and s_tready drops.
  always @(negedge clk) begin
    if (rx_hold_off != 0) begin
      rx_hold_off = rx_hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= 14;
    end
  end

  // Monitor: predicts each accepted input word and checks each accepted
  // output word against the oldest prediction.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        expected_reports.push_back(apply_word(cmd_t'(s_tdata[CMD_W-1:0]),
                                              s_tdata[CMD_W +: BUTTONS]));
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[OUT_RAW_W-1:0];
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output word %h at %0t", m_tdata, $realtime);
        end else begin
          want = expected_reports.pop_front();
          if (got.btns !== want.btns || got.ev_valid !== want.ev_valid ||
              got.ev_btns !== want.ev_btns || got.hold !== want.hold ||
              got.waiting !== want.waiting) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at %0t: expected btns=%h valid=%b ev=%h hold=%b waiting=%0d",
                       $realtime, want.btns, want.ev_valid, want.ev_btns, want.hold,
                       want.waiting);
              $display("  got btns=%h valid=%b ev=%h hold=%b waiting=%0d",
                       got.btns, got.ev_valid, got.ev_btns, got.hold, got.waiting);
            end
          end
        end
      end
    end
  end

  function automatic logic [BUTTONS-1:0] rand_keys();
    return BUTTONS'($urandom_range(0, (1 << BUTTONS) - 1));
  endfunction

  task automatic add_word(cmd_t cmd, logic [BUTTONS-1:0] keys);
    key_word_t w;
    w.cmd  = cmd;
    w.keys = keys;
    key_words_pending.push_back(w);
    queued_words++;
  endtask

  // A tick, sometimes preceded by a pop so that reads interleave with the
  // debounce activity.
  task automatic add_tick(logic [BUTTONS-1:0] keys);
    if ($urandom_range(0, 9) == 0) add_word(CMD_POP, rand_keys());
    add_word(CMD_TICK, keys);
  endtask

  // A well-formed press episode: contact bounce, a held pattern that may
  // change while held, bounce on release, a stable release, then some pops and at times a clear or an unused command.
  task automatic add_press_episode();
    logic [BUTTONS-1:0] keys;
    int                 top;
    int                 held;
    keys = BUTTONS'($urandom_range(1, (1 << BUTTONS) - 1));
    repeat ($urandom_range(0, 3)) add_tick(rand_keys());
    // Long presses reach the hold and a few repeats under the current setting.
    top = cfg_hold + 2 * cfg_repeat + cfg_debounce + 8;
    if (top > 300) top = 300;
    if (top < 40) top = 40;
    if ($urandom_range(0, 3) == 0) held = $urandom_range(1, top);
    else held = $urandom_range(1, 2 * cfg_debounce + 6);
    for (int n = 0; n < held; n++) begin
      if ($urandom_range(0, 29) == 0) keys = BUTTONS'($urandom_range(1, (1 << BUTTONS) - 1));
      add_tick(keys);
    end
    repeat ($urandom_range(0, 3)) add_tick(rand_keys());
    repeat ($urandom_range(1, cfg_debounce + 4)) add_tick('0);
    repeat ($urandom_range(0, 3)) add_word(CMD_POP, rand_keys());
    if ($urandom_range(0, 19) == 0) add_word(CMD_CLEAR, rand_keys());
    if ($urandom_range(0, 29) == 0) add_word(CMD_NONE, rand_keys());
  endtask

  // Waits until every word has been driven and every result has come back,
  // then lets the two pipeline stages settle.
  task automatic wait_for_idle();
    do begin
      @(posedge clk);
      #1;
    end while (key_words_pending.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly press episodes, the rest random words of any command.
  task automatic run_random(int count, int stall_cycles);
    int unsigned goal;
    goal = queued_words + count;
    while (queued_words < goal) begin
      if ($urandom_range(0, 99) < 85) begin
        add_press_episode();
      end else begin
        repeat ($urandom_range(1, 6)) add_word(cmd_t'($urandom_range(0, 3)), rand_keys());
      end
    end
    if (stall_cycles != 0) begin
      @(posedge clk);
      rx_hold_off = stall_cycles;
    end
    wait_for_idle();
  endtask

  // Register writes happen only with the block idle; the model copy changes
  // at the same moment, and bits above a register's width are dropped.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_DEBOUNCE: cfg_debounce = value[DEB_W-1:0];
      REG_HOLD:     cfg_hold     = value[AGE_W-1:0];
      REG_REPEAT:   cfg_repeat   = value[AGE_W-1:0];
      REG_FEATURES: cfg_features = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset configuration: every command, empty
    // pops, all buttons and no buttons, bounce, release events and a clear.
    add_word(CMD_POP, '0);
    add_word(CMD_NONE, '1);
    add_word(CMD_CLEAR, '0);
    repeat (5) add_word(CMD_TICK, '1);
    add_word(CMD_POP, '1);
    add_word(CMD_TICK, 7'h2A);
    repeat (5) add_word(CMD_TICK, '0);
    add_word(CMD_POP, '0);
    repeat (4) add_word(CMD_TICK, 7'h01);
    repeat (4) add_word(CMD_TICK, '0);
    add_word(CMD_CLEAR, 7'h55);
    add_word(CMD_POP, '0);
    wait_for_idle();
    run_random(120, 0);

    // Short hold and repeat: many hold events, the queue overflows, and a
    // long output stall backs the block up.
    write_reg(REG_DEBOUNCE, 16'd1);
    write_reg(REG_HOLD, 16'd3);
    write_reg(REG_REPEAT, 16'd2);
    run_random(150, 80);

    // Zero debounce, no repeat, and no idling on either side.
    calm = 1'b1;
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_HOLD, 16'd5);
    write_reg(REG_REPEAT, 16'd0);
    run_random(100, 0);
    calm = 1'b0;

    // Hold disabled while repeat is set.
    write_reg(REG_DEBOUNCE, 16'd2);
    write_reg(REG_HOLD, 16'd0);
    write_reg(REG_REPEAT, 16'd7);
    run_random(80, 0);

    // Hold features off; the upper data bits must be ignored.
    write_reg(REG_FEATURES, 16'hFFFE);
    write_reg(REG_DEBOUNCE, 16'hA503);
    write_reg(REG_HOLD, 16'd4);
    write_reg(REG_REPEAT, 16'd2);
    run_random(120, 0);

    // Largest debounce with the longest hold and repeat; the debounce count
    // saturates during both runs.
    write_reg(REG_FEATURES, 16'h0001);
    write_reg(REG_DEBOUNCE, 16'd255);
    write_reg(REG_HOLD, 16'hFFFF);
    write_reg(REG_REPEAT, 16'hFFFF);
    repeat (258) add_word(CMD_TICK, '1);
    repeat (258) add_word(CMD_TICK, '0);
    add_word(CMD_POP, '0);
    wait_for_idle();

    // One press held with the timer off, so the hold age runs well past the
    // new hold setting. Arming the hold afterwards must fire at once.
    calm = 1'b1;
    write_reg(REG_DEBOUNCE, 16'd1);
    write_reg(REG_HOLD, 16'd0);
    write_reg(REG_REPEAT, 16'd0);
    repeat (60) add_word(CMD_TICK, 7'h55);
    wait_for_idle();
    write_reg(REG_HOLD, 16'd40);
    add_word(CMD_TICK, 7'h55);
    add_word(CMD_POP, '0);
    repeat (2) add_word(CMD_TICK, '0);
    add_word(CMD_POP, '0);
    wait_for_idle();
    calm = 1'b0;

    // Moderate settings to close.
    write_reg(REG_DEBOUNCE, 16'd3);
    write_reg(REG_HOLD, 16'd10);
    write_reg(REG_REPEAT, 16'd4);
    run_random(120, 0);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard limit, many times the slowest legal run.
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: button_debounce_event_queue.f
hw/rtl/bde_pkg.sv
hw/rtl/bde_debounce.sv
hw/rtl/bde_event_queue.sv
hw/rtl/button_debounce_event_queue.sv
dv/tb.sv
